@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the UBX frame receiver.
// Depends on a clk and rst signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/ubx_pkg.sv @@
// Types and constants of the UBX frame receiver.
// Used by the parser, the result queue and the top level.
package ubx_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic        checksum_ok;
  } ubx_result_t;

endpackage

@@ design/ubx_parser.sv @@
// Front end: sync hunt, header capture, Fletcher checksum and result build.
// Depends on ubx_pkg.
module ubx_parser import ubx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        res_valid,
  output ubx_result_t res
);

  phase_t      phase, phase_next;
  logic [15:0] payload_count, payload_count_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  received_sum_a, received_sum_a_next;
  logic [15:0] max_len;

  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [7:0]  sum_a_add;

  assign len_full  = {in_byte, frame_length[7:0]};
  assign count_inc = payload_count + 16'd1;
  assign sum_a_add = sum_a + in_byte;

  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      case (phase)
        PH_SYNC1:   if (in_byte == SYNC_FIRST) phase_next = PH_SYNC2;
        PH_SYNC2:   phase_next = (in_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
        PH_CLASS:   phase_next = PH_ID;
        PH_ID:      phase_next = PH_LEN_LO;
        PH_LEN_LO:  phase_next = PH_LEN_HI;
        PH_LEN_HI: begin
          if (len_full == 16'd0) phase_next = PH_CK_A;
          else if (len_full > max_len) phase_next = PH_SYNC1;
          else phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: if (count_inc == frame_length) phase_next = PH_CK_A;
        PH_CK_A:    phase_next = PH_CK_B;
        PH_CK_B:    phase_next = PH_SYNC1;
        default:    phase_next = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    payload_count_next  = payload_count;
    frame_length_next   = frame_length;
    frame_class_next    = frame_class;
    frame_id_next       = frame_id;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    received_sum_a_next = received_sum_a;
    res_valid           = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.payload_byte    = 8'd0;
    res.byte_index      = 16'd0;
    res.msg_class       = frame_class;
    res.msg_id          = frame_id;
    res.payload_length  = frame_length;
    res.checksum_ok     = 1'b0;
    if (in_valid) begin
      case (phase)
        PH_CLASS: begin
          sum_a_next       = in_byte;
          sum_b_next       = in_byte;
          frame_class_next = in_byte;
        end
        PH_ID: begin
          sum_a_next    = sum_a_add;
          sum_b_next    = sum_b + sum_a_add;
          frame_id_next = in_byte;
        end
        PH_LEN_LO: begin
          sum_a_next        = sum_a_add;
          sum_b_next        = sum_b + sum_a_add;
          frame_length_next = {8'd0, in_byte};
        end
        PH_LEN_HI: begin
          sum_a_next         = sum_a_add;
          sum_b_next         = sum_b + sum_a_add;
          frame_length_next  = len_full;
          payload_count_next = 16'd0;
          if (len_full != 16'd0 && len_full > max_len) begin
            res_valid          = 1'b1;
            res.kind           = KIND_DROP;
            res.payload_length = len_full;
          end
        end
        PH_PAYLOAD: begin
          sum_a_next       = sum_a_add;
          sum_b_next       = sum_b + sum_a_add;
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = in_byte;
          res.byte_index   = payload_count;
          payload_count_next = (count_inc == frame_length) ? 16'd0 : count_inc;
        end
        PH_CK_A: received_sum_a_next = in_byte;
        PH_CK_B: begin
          res_valid          = 1'b1;
          res.kind           = KIND_FRAME;
          res.checksum_ok    = (received_sum_a == sum_a) && (in_byte == sum_b);
          payload_count_next = 16'd0;
        end
        PH_SYNC1, PH_SYNC2: ;
        default: payload_count_next = 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      payload_count <= 16'd0;
      max_len       <= MAX_LEN_RESET;
    end else begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      if (cfg_we) max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    frame_length   <= frame_length_next;
    frame_class    <= frame_class_next;
    frame_id       <= frame_id_next;
    sum_a          <= sum_a_next;
    sum_b          <= sum_b_next;
    received_sum_a <= received_sum_a_next;
  end

endmodule

@@ design/ubx_result_fifo.sv @@
// Back end: short queue of result words between the parser and the output.
// Depends on ubx_pkg.
module ubx_result_fifo import ubx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  ubx_result_t wr_data,
  input  logic        rd_en,
  output logic        full,
  output logic        empty,
  output ubx_result_t rd_data
);

  ubx_result_t        entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

@@ design/ubx_frame_receiver.sv @@
// UBX frame receiver: one byte accepted per cycle while full is low.
// A result produced by an accepted byte is written at that byte's accept edge, so empty is low just after it.
// A four-word result queue decouples the parser from pop; full rises when it holds four.
// Synchronous reset: hunt first sync byte, empty queue, max payload length 512.
// Depends on ubx_pkg, ubx_parser, ubx_result_fifo and assert_macros.svh.
`include "assert_macros.svh"
module ubx_frame_receiver import ubx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] byte_index,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_length,
  output logic        checksum_ok,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        in_valid;
  logic        res_valid;
  ubx_result_t res;
  ubx_result_t head;

  assign in_valid = push && !full;

  ubx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  ubx_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .full    (full),
    .empty   (empty),
    .rd_data (head)
  );

  assign kind           = head.kind;
  assign payload_byte   = head.payload_byte;
  assign byte_index     = head.byte_index;
  assign msg_class      = head.msg_class;
  assign msg_id         = head.msg_id;
  assign payload_length = head.payload_length;
  assign checksum_ok    = head.checksum_ok;

  `ASSERT_IMPLY(a_res_needs_accept, res_valid, in_valid, "result without accepted byte")
  `ASSERT_IMPLY(a_non_payload_clear, !empty && head.kind != KIND_PAYLOAD, payload_byte == 8'd0 && byte_index == 16'd0, "payload fields set on non-payload word")
  `ASSERT_IMPLY(a_ok_only_frame, !empty && head.kind != KIND_FRAME, !checksum_ok, "checksum flag on non-frame word")
  `ASSERT_NEXT(a_empty_holds, empty && !in_valid, empty, "queue filled without accepted byte")

endmodule
